@@ rtl/arp_cache_with_aging_macros.svh @@
// ----------------------------------------------------------------------------
// ARP cache assertion macros
// Shorthand for the clocked, reset-qualified checks of the ARP cache.
// ----------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_AGING_MACROS_SVH
`define ARP_CACHE_WITH_AGING_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ARPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ARPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache package
// Beat types, operation codes and constants shared by the ARP cache modules.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam logic [15:0] TIMEOUT_RST = 16'd20;
  localparam logic [15:0] AGE_MAX     = 16'hFFFF;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] ip_addr;
    logic [47:0] hw_addr;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] found_hw_addr;
    logic        evicted;
  } out_t;

  // Search record handed from cell to cell.
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] ip;
    logic        match_f;
    logic [47:0] found_hw;
    logic        free_f;
    logic [15:0] old_age;
  } scan_t;

  // Write-back command broadcast to all cells.
  typedef struct packed {
    logic        en;
    logic [31:0] ip;
    logic [47:0] hw;
  } wr_t;

endpackage

@@ rtl/arpc_cell.sv @@
// ----------------------------------------------------------------------------
// ARP cache cell
// Holds one table entry, folds it into the passing search record and ages it.
// ----------------------------------------------------------------------------
module arpc_cell #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF,
  parameter int unsigned SLOT    = 0,
  localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         timeout_i,
  input  logic                scan_valid_i,
  input  arpc_pkg::scan_t     scan_i,
  input  logic [IDX_W-1:0]    match_idx_i,
  input  logic [IDX_W-1:0]    free_idx_i,
  input  logic [IDX_W-1:0]    old_idx_i,
  output logic                scan_valid_o,
  output arpc_pkg::scan_t     scan_o,
  output logic [IDX_W-1:0]    match_idx_o,
  output logic [IDX_W-1:0]    free_idx_o,
  output logic [IDX_W-1:0]    old_idx_o,
  input  arpc_pkg::wr_t       wr_i,
  input  logic [IDX_W-1:0]    wr_idx_i
);
  import arpc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(SLOT);

  logic             valid_q, valid_d;
  logic [31:0]      ip_q;
  logic [47:0]      hw_q;
  logic [15:0]      age_q, age_d;
  logic             scan_valid_q;
  scan_t            scan_q, scan_d;
  logic [IDX_W-1:0] match_idx_q, match_idx_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [IDX_W-1:0] old_idx_q, old_idx_d;
  logic             live;
  logic             wr_hit;
  logic             tick_hit;

  assign live     = valid_q && (age_q < timeout_i);
  assign wr_hit   = wr_i.en && (wr_idx_i == MY_IDX);
  assign tick_hit = scan_valid_i && (scan_i.func == FUNC_TICK) && valid_q;

  always_comb begin
    scan_d      = scan_i;
    match_idx_d = match_idx_i;
    free_idx_d  = free_idx_i;
    old_idx_d   = old_idx_i;
    // first live match wins
    if (!scan_i.match_f && live && (ip_q == scan_i.ip)) begin
      scan_d.match_f  = 1'b1;
      scan_d.found_hw = hw_q;
      match_idx_d     = MY_IDX;
    end
    if (!scan_i.free_f && !live) begin
      scan_d.free_f = 1'b1;
      free_idx_d    = MY_IDX;
    end
    // strictly older only, so the lowest slot keeps a tie
    if (age_q > scan_i.old_age) begin
      scan_d.old_age = age_q;
      old_idx_d      = MY_IDX;
    end
  end

  always_comb begin
    age_d   = (age_q == AGE_MAX) ? age_q : age_q + 16'd1;
    valid_d = age_d < timeout_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      scan_valid_q <= 1'b0;
    end else begin
      scan_valid_q <= scan_valid_i;
      if (wr_hit) begin
        valid_q <= 1'b1;
      end else if (tick_hit) begin
        valid_q <= valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      ip_q  <= wr_i.ip;
      hw_q  <= wr_i.hw;
      age_q <= '0;
    end else if (tick_hit) begin
      age_q <= age_d;
    end
    if (scan_valid_i) begin
      scan_q      <= scan_d;
      match_idx_q <= match_idx_d;
      free_idx_q  <= free_idx_d;
      old_idx_q   <= old_idx_d;
    end
  end

  assign scan_valid_o = scan_valid_q;
  assign scan_o       = scan_q;
  assign match_idx_o  = match_idx_q;
  assign free_idx_o   = free_idx_q;
  assign old_idx_o    = old_idx_q;

endmodule

@@ rtl/arp_cache_with_aging.sv @@
// The search record walks the chain one cell per cycle; at the tail the controller
// resolves it into the result and write-back registers, and the finish state
// writes back and emits the result. A new beat is taken only once the controller
// is back in idle, so a beat is not accepted while the previous one is in flight.
// A result held by the receiver holds the controller and so the input.
// Reset: all entries invalid, timeout back to 20 ticks; ready from the first cycle.
// ----------------------------------------------------------------------------
// ARP cache with aging
// IPv4 to hardware address table built as a chain of entry cells with a
// small controller that launches searches, writes back inserts and returns
// one result beat per input beat.
// ----------------------------------------------------------------------------
module arp_cache_with_aging #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  arpc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output arpc_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i
);
  import arpc_pkg::*;
  `include "arp_cache_with_aging_macros.svh"

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [15:0]      timeout_q;
  logic             hd_valid_q;
  scan_t            hd_q;
  logic [47:0]      cmd_hw_q;
  out_t             res_q, res_d;
  wr_t              wr_q, wr_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic             out_valid_q;
  out_t             out_q;
  logic             in_fire;
  logic             tail_fire;
  logic             out_load;

  logic             chain_valid [ENTRIES+1];
  scan_t            chain       [ENTRIES+1];
  logic [IDX_W-1:0] chain_midx  [ENTRIES+1];
  logic [IDX_W-1:0] chain_fidx  [ENTRIES+1];
  logic [IDX_W-1:0] chain_oidx  [ENTRIES+1];
  logic [ENTRIES:0] chain_valid_vec;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign tail_fire  = (state_q == ST_SCAN) && chain_valid[ENTRIES];
  assign out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  assign chain_valid[0] = hd_valid_q;
  assign chain[0]       = hd_q;
  assign chain_midx[0]  = '0;
  assign chain_fidx[0]  = '0;
  assign chain_oidx[0]  = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .ENTRIES (ENTRIES),
      .SLOT    (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .timeout_i    (timeout_q),
      .scan_valid_i (chain_valid[g]),
      .scan_i       (chain[g]),
      .match_idx_i  (chain_midx[g]),
      .free_idx_i   (chain_fidx[g]),
      .old_idx_i    (chain_oidx[g]),
      .scan_valid_o (chain_valid[g+1]),
      .scan_o       (chain[g+1]),
      .match_idx_o  (chain_midx[g+1]),
      .free_idx_o   (chain_fidx[g+1]),
      .old_idx_o    (chain_oidx[g+1]),
      .wr_i         (wr_q),
      .wr_idx_i     (wr_idx_q)
    );
  end

  for (genvar g = 0; g <= ENTRIES; g++) begin : g_vld
    assign chain_valid_vec[g] = chain_valid[g];
  end

  // Resolve the finished search into a result and, for an insert, a target slot.
  always_comb begin
    res_d    = '0;
    wr_d     = '0;
    wr_idx_d = wr_idx_q;
    case (chain[ENTRIES].func)
      FUNC_INSERT: begin
        wr_d.en = 1'b1;
        wr_d.ip = chain[ENTRIES].ip;
        wr_d.hw = cmd_hw_q;
        if (chain[ENTRIES].match_f) begin
          wr_idx_d = chain_midx[ENTRIES];
        end else if (chain[ENTRIES].free_f) begin
          wr_idx_d = chain_fidx[ENTRIES];
        end else begin
          wr_idx_d      = chain_oidx[ENTRIES];
          res_d.evicted = 1'b1;
        end
      end
      FUNC_LOOKUP: begin
        res_d.hit           = chain[ENTRIES].match_f;
        res_d.found_hw_addr = chain[ENTRIES].found_hw;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_SCAN;
      ST_SCAN: if (tail_fire) state_d = ST_FIN;
      ST_FIN:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= TIMEOUT_RST;
      hd_valid_q  <= 1'b0;
      wr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      hd_valid_q <= in_fire;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      // write-back is a single-cycle pulse
      wr_q <= tail_fire ? wr_d : '0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hd_q.func     <= in_data_i.func;
      hd_q.ip       <= in_data_i.ip_addr;
      hd_q.match_f  <= 1'b0;
      hd_q.found_hw <= '0;
      hd_q.free_f   <= 1'b0;
      hd_q.old_age  <= '0;
      cmd_hw_q      <= in_data_i.hw_addr;
    end
    if (tail_fire) begin
      res_q    <= res_d;
      wr_idx_q <= wr_idx_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ARPC_ASSERT_NEXT(a_launch, in_fire, hd_valid_q && (state_q == ST_SCAN), "search not launched")
  `ARPC_ASSERT_NOW(a_one_rec, 1'b1, $countones(chain_valid_vec) <= 1, "several records in chain")
  `ARPC_ASSERT_NOW(a_wr_fin, wr_q.en, state_q == ST_FIN, "write-back outside finish")
  `ARPC_ASSERT_NOW(a_tail_scan, chain_valid[ENTRIES], state_q == ST_SCAN, "record left chain unexpectedly")

endmodule

@@ verif/arp_cache_with_aging_tb.sv @@
// ----------------------------------------------------------------------------
// ARP cache with aging testbench
// Drives insert, lookup and tick beats through the valid/ready input, keeps a
// mirror of the address table to work out each reply, and compares every
// reply beat field by field, across several timeout settings.
// ----------------------------------------------------------------------------
module arp_cache_with_aging_tb;
  import arpc_pkg::*;

  localparam int unsigned N_SLOTS     = ENTRIES_DEF;
  localparam int unsigned LATENCY     = N_SLOTS + 2;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned POOL_SIZE   = 32;
  localparam longint unsigned RUN_LIMIT = 64'd12 * 64'd400_000;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  // Mirror of the address table; one reply is due per accepted request.
  class arp_table_mirror;
    logic [15:0] timeout_ticks = TIMEOUT_RST;
    bit          slot_valid [N_SLOTS];
    logic [31:0] slot_ip    [N_SLOTS];
    logic [47:0] slot_hw    [N_SLOTS];
    logic [15:0] slot_age   [N_SLOTS];
    out_t        replies_due[$];
    int unsigned errors;
    int unsigned n_req, n_insert, n_lookup, n_hit, n_tick, n_evict;

    function void clear_table();
      foreach (slot_valid[s]) begin
        slot_valid[s] = 1'b0;
        slot_ip[s]    = '0;
        slot_hw[s]    = '0;
        slot_age[s]   = '0;
      end
      timeout_ticks = TIMEOUT_RST;
    endfunction

    function bit slot_live(int s);
      return slot_valid[s] && (slot_age[s] < timeout_ticks);
    endfunction

    function int find_live(logic [31:0] ip);
      for (int s = N_SLOTS - 1; s >= 0; s--)
        if (slot_live(s) && slot_ip[s] == ip) find_live = s;
      if (find_live == 0 && !(slot_live(0) && slot_ip[0] == ip)) find_live = -1;
    endfunction

    function void take_request(in_t req);
      out_t rep;
      int   slot;
      rep = '0;
      n_req++;
      case (req.func)
        FUNC_INSERT: begin
          n_insert++;
          slot = find_live(req.ip_addr);
          for (int s = 0; s < N_SLOTS; s++)
            if (slot < 0 && !slot_live(s)) slot = s;
          // table full of live entries: replace the oldest, lowest index on a tie
          if (slot < 0) begin
            slot = 0;
            for (int s = 1; s < N_SLOTS; s++)
              if (slot_age[s] > slot_age[slot]) slot = s;
            rep.evicted = 1'b1;
            n_evict++;
          end
          slot_valid[slot] = 1'b1;
          slot_ip[slot]    = req.ip_addr;
          slot_hw[slot]    = req.hw_addr;
          slot_age[slot]   = '0;
        end
        FUNC_LOOKUP: begin
          n_lookup++;
          slot = find_live(req.ip_addr);
          if (slot >= 0) begin
            rep.hit           = 1'b1;
            rep.found_hw_addr = slot_hw[slot];
            n_hit++;
          end
        end
        FUNC_TICK: begin
          n_tick++;
          foreach (slot_valid[s]) begin
            if (slot_valid[s]) begin
              if (slot_age[s] != AGE_MAX) slot_age[s]++;
              if (slot_age[s] >= timeout_ticks) slot_valid[s] = 1'b0;
            end
          end
        end
        default: ;
      endcase
      replies_due.push_back(rep);
    endfunction

    function void match_reply(out_t got);
      out_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("reply beat with none due: hit=%0b hw=%012h evicted=%0b",
                   got.hit, got.found_hw_addr, got.evicted);
        return;
      end
      want = replies_due.pop_front();
      if (got.hit !== want.hit || got.found_hw_addr !== want.found_hw_addr ||
          got.evicted !== want.evicted) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("reply mismatch: expected hit=%0b hw=%012h evicted=%0b, got hit=%0b hw=%012h evicted=%0b",
                   want.hit, want.found_hw_addr, want.evicted,
                   got.hit, got.found_hw_addr, got.evicted);
      end
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_t        out_data_o;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  arp_table_mirror tracker;
  logic [31:0]     ip_pool [POOL_SIZE];
  int unsigned     pool_n;
  int unsigned     gap_pct, stall_pct, tick_pct;
  int unsigned     n_cfg;
  bit              no_idle;
  bit              hold_req;

  arp_cache_with_aging dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.match_reply(out_data_o);
  end

  // Reply side: random stall bursts, or one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(99) < stall_pct) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  function automatic in_t make_req(logic [1:0] func, logic [31:0] ip, logic [47:0] hw);
    in_t r;
    r.func    = func;
    r.ip_addr = ip;
    r.hw_addr = hw;
    return r;
  endfunction

  function automatic in_t random_req();
    in_t         r;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < tick_pct)          r.func = FUNC_TICK;
    else if (roll < tick_pct + 3) r.func = FUNC_NONE;
    else if ($urandom_range(1))   r.func = FUNC_INSERT;
    else                          r.func = FUNC_LOOKUP;
    // mostly pool addresses, so that lookups hit and inserts collide
    r.ip_addr = ($urandom_range(9) == 0) ? $urandom : ip_pool[$urandom_range(pool_n - 1)];
    r.hw_addr = {16'($urandom), 32'($urandom)};
    return r;
  endfunction

  task automatic offer(input in_t req);
    if (!no_idle && $urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = req;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_request(req);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = ticks;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tracker.timeout_ticks = ticks;
    n_cfg++;
  endtask

  task automatic run_phase(input logic [15:0] ticks, input int unsigned n_items,
                           input int unsigned gap, input int unsigned stall,
                           input int unsigned tick_share, input bit hold);
    drain();
    write_timeout(ticks);
    gap_pct   = gap;
    stall_pct = stall;
    tick_pct  = tick_share;
    pool_n    = $urandom_range(12, POOL_SIZE);
    for (int i = 0; i < n_items; i++) begin
      if (hold && i == 20) hold_req = 1'b1;
      // hold back until the table has answered everything
      if (i == n_items / 2) drain();
      offer(random_req());
    end
  endtask

  initial begin
    tracker = new;
    tracker.clear_table();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    no_idle     = 1'b0;
    hold_req    = 1'b0;
    n_cfg       = 0;
    gap_pct     = 20;
    stall_pct   = 20;
    tick_pct    = 10;
    ip_pool[0]  = '0;
    ip_pool[1]  = '1;
    for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
    pool_n = POOL_SIZE;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table, unused code, extremes, overwrite, then fill and evict
    offer(make_req(FUNC_LOOKUP, 32'h0, '1));
    offer(make_req(FUNC_TICK, 32'h0, '0));
    offer(make_req(FUNC_NONE, '1, '1));
    offer(make_req(FUNC_INSERT, 32'h0, 48'h0));
    offer(make_req(FUNC_INSERT, '1, '1));
    offer(make_req(FUNC_LOOKUP, 32'h0, '0));
    offer(make_req(FUNC_LOOKUP, '1, '0));
    offer(make_req(FUNC_INSERT, '1, 48'h5555_5555_5555));
    offer(make_req(FUNC_LOOKUP, '1, '0));
    offer(make_req(FUNC_TICK, 32'h0, '0));
    for (int i = 2; i < N_SLOTS; i++)
      offer(make_req(FUNC_INSERT, ip_pool[i], {16'hAAAA, ip_pool[i]}));
    offer(make_req(FUNC_INSERT, 32'h0A00_0001, 48'h0000_5EC0_FFEE));
    offer(make_req(FUNC_LOOKUP, 32'h0, '0));
    offer(make_req(FUNC_LOOKUP, '1, '0));

    run_phase(16'hFFFF, 130, 30, 30, 15, 1'b1);
    run_phase(16'd3,    120, 20, 20, 20, 1'b0);
    run_phase(16'd1,     80, 25, 25, 10, 1'b0);
    run_phase(16'd0,     40, 20, 20, 15, 1'b0);
    run_phase(16'd2,    100,  0,  0, 15, 1'b0);
    run_phase(16'($urandom_range(4, 30)), 150, 35, 35, 12, 1'b0);
    run_phase(16'd12,   130, 20, 20,  8, 1'b0);
    run_phase(16'd5,    120, 30, 30, 10, 1'b0);
    no_idle = 1'b1;
    run_phase(TIMEOUT_RST, 180, 0, 0, 10, 1'b0);

    drain();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      tracker.errors++;
      $display("%0d reply beats never arrived", tracker.pending());
    end
    $display("covered %0d requests: %0d inserts (%0d evictions), %0d lookups (%0d hits), %0d ticks",
             tracker.n_req, tracker.n_insert, tracker.n_evict, tracker.n_lookup,
             tracker.n_hit, tracker.n_tick);
    $display("over %0d timeout settings, %0d errors", n_cfg, tracker.errors);
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
